@@ hdl/rlrt_pkg.sv @@
// Package for the refcounted LRU residency table.
// Holds the function, status and result codes and the slot record types.
// No dependencies.
package rlrt_pkg;

    typedef enum logic [2:0] {
        FUNC_ACQUIRE   = 3'd0,
        FUNC_RETAIN    = 3'd1,
        FUNC_RELEASE   = 3'd2,
        FUNC_COMPLETE  = 3'd3,
        FUNC_EVICT_ALL = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_STALE     = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_FULL      = 3'd4,
        ST_SATURATED = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        RK_STATUS  = 2'd0,
        RK_REQUEST = 2'd1,
        RK_EVICT   = 2'd2
    } t_result_kind;

    localparam logic [15:0] REF_MAX   = 16'hFFFF;
    localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] CLOCK_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] asset;
        logic [15:0] refs;
        logic        in_lru;
        logic [63:0] stamp;
        logic [47:0] bytes;
    } t_slot;

    typedef struct packed {
        logic [31:0] asset;
        logic [47:0] bytes;
    } t_victim;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  status;
        logic [31:0] out_asset_id;
        logic [3:0]  out_kind;
        logic [7:0]  out_lod;
        logic [1:0]  out_priority;
        logic        hit;
        logic [47:0] freed_bytes;
        logic        last;
    } t_rsp;

endpackage

@@ hdl/rlrt_ifs.sv @@
// Request and result channel interfaces for the residency table.
// Valid/ready handshake with the payload fields; no package dependency.
interface rlrt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] asset_id;
    logic [3:0]  asset_kind;
    logic [7:0]  lod;
    logic [1:0]  priority_req;
    logic [47:0] payload_bytes;
    logic        load_ok;

    modport source (output valid, func, asset_id, asset_kind, lod, priority_req,
                    payload_bytes, load_ok, input ready);
    modport sink (input valid, func, asset_id, asset_kind, lod, priority_req,
                  payload_bytes, load_ok, output ready);
endinterface

interface rlrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [2:0]  status;
    logic [31:0] out_asset_id;
    logic [3:0]  out_kind;
    logic [7:0]  out_lod;
    logic [1:0]  out_priority;
    logic        hit;
    logic [47:0] freed_bytes;
    logic [47:0] resident_total;
    logic [5:0]  live_entries;
    logic [5:0]  evicted_count;
    logic        last;

    modport source (output valid, result_kind, status, out_asset_id, out_kind, out_lod,
                    out_priority, hit, freed_bytes, resident_total, live_entries,
                    evicted_count, last, input ready);
    modport sink (input valid, result_kind, status, out_asset_id, out_kind, out_lod,
                  out_priority, hit, freed_bytes, resident_total, live_entries,
                  evicted_count, last, output ready);
endinterface

@@ hdl/refcounted_lru_residency_table_core.sv @@
// Top level of the refcounted LRU residency table with a byte budget.
// Depends on rlrt_pkg and the channel interfaces in rlrt_ifs.sv.
//
//  channel   dir  handshake                beat
//  i_req     in   valid/ready              one request (func, id, kind, lod, ...)
//  o_rsp     out  valid/ready              one result; last marks the status beat
//  apb       in   psel/penable/pready      byte_budget at address 0, 64-bit data
//
// The slot memory is walked through one read port, a read and a check state per slot
// (S_FRD/S_FCHK for a lookup, S_ORD/S_OCHK for a victim scan); every lookup walks all
// slots. A completion adds S_ADD and a budget check. Each eviction takes a full scan,
// and a drain ends with one empty scan. Each eviction beat is read from the victim queue
// (S_EVRD) before it is sent; ready returns once the status beat is taken. Reset is synchronous;
// the slot memory needs no clearing pass. A stalled o_rsp holds the sequencer.
module refcounted_lru_residency_table_core #(
    parameter int ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlrt_req_if.sink    i_req,
    rlrt_rsp_if.source  o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_FRD   = 13'b0000000000010,
        S_FCHK  = 13'b0000000000100,
        S_UPD   = 13'b0000000001000,
        S_ADD   = 13'b0000000010000,
        S_BUD   = 13'b0000000100000,
        S_ORD   = 13'b0000001000000,
        S_OCHK  = 13'b0000010000000,
        S_EVICT = 13'b0000100000000,
        S_EREQ  = 13'b0001000000000,
        S_EVRD  = 13'b0010000000000,
        S_EVOUT = 13'b0100000000000,
        S_EST   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;

    rlrt_pkg::t_slot   mem [ENTRIES];
    rlrt_pkg::t_victim evq [ENTRIES];
    rlrt_pkg::t_slot   r_rd;
    rlrt_pkg::t_victim r_evrd;

    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0]      r_live, r_evc, r_ei;
    logic [47:0]        r_total, r_budget, r_b;
    logic [63:0]        r_clock;
    logic [IW-1:0]      r_idx, r_fidx, r_freeidx, r_bidx;
    logic               r_found, r_freeok, r_bok, r_req;
    rlrt_pkg::t_slot    r_rec;
    logic [63:0]        r_bstamp;
    logic [31:0]        r_basset;
    logic [47:0]        r_bbytes;
    logic [2:0]         r_status;
    logic               r_hit;

    logic [2:0]  r_func;
    logic [31:0] r_id;
    logic [3:0]  r_kind;
    logic [7:0]  r_lod;
    logic [1:0]  r_prio;
    logic [47:0] r_payload;
    logic        r_ok;

    logic           r_ov;
    rlrt_pkg::t_rsp r_out;

    logic            we;
    logic [IW-1:0]   waddr;
    rlrt_pkg::t_slot wdata;
    logic            ld_ok, accept, cfg_wr, beat_ld;
    logic [63:0]     clk_inc;
    logic [48:0]     sum;
    logic [47:0]     evict_total;

    assign ld_ok  = !r_ov || o_rsp.ready;
    assign accept = i_req.valid && i_req.ready;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == 4'd0);
    assign pready = 1'b1;
    assign prdata = (paddr == 4'd0) ? {16'd0, r_budget} : 64'd0;
    assign i_req.ready = (r_state == S_IDLE) && !r_ov;
    assign beat_ld = ld_ok && ((r_state == S_EREQ && r_req) || r_state == S_EVOUT ||
                               r_state == S_EST);

    assign clk_inc     = (r_clock == rlrt_pkg::CLOCK_MAX) ? r_clock : r_clock + 64'd1;
    assign sum         = {1'b0, r_total} + {1'b0, r_b};
    assign evict_total = (r_bbytes > r_total) ? 48'd0 : r_total - r_bbytes;

    always_ff @(posedge i_clk) begin
        r_rd   <= mem[r_idx];
        r_evrd <= evq[r_ei[IW-1:0]];
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (r_state == S_EVICT) begin
            evq[r_evc[IW-1:0]] <= '{asset: r_basset, bytes: r_bbytes};
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_fidx;
        wdata = r_rec;
        if (r_state == S_UPD) begin
            unique case (r_func)
                rlrt_pkg::FUNC_ACQUIRE: begin
                    if (r_found) begin
                        we = 1'b1;
                        wdata.in_lru = 1'b0;
                        if (r_rec.refs != rlrt_pkg::REF_MAX) begin
                            wdata.refs = r_rec.refs + 16'd1;
                        end
                    end else if (r_freeok) begin
                        we = 1'b1;
                        waddr = r_freeidx;
                        wdata = '{asset: r_id, refs: 16'd1, in_lru: 1'b0,
                                  stamp: 64'd0, bytes: 48'd0};
                    end
                end
                rlrt_pkg::FUNC_RETAIN: begin
                    we = 1'b1;
                    if (r_rec.refs == 16'd0) begin
                        wdata.in_lru = 1'b0;
                    end
                    if (r_rec.refs != rlrt_pkg::REF_MAX) begin
                        wdata.refs = r_rec.refs + 16'd1;
                    end
                end
                rlrt_pkg::FUNC_RELEASE: begin
                    if (r_rec.refs != 16'd0) begin
                        we = 1'b1;
                        wdata.refs = r_rec.refs - 16'd1;
                        if (r_rec.refs == 16'd1) begin
                            wdata.stamp  = clk_inc;
                            wdata.in_lru = 1'b1;
                        end
                    end
                end
                rlrt_pkg::FUNC_COMPLETE: begin
                    we = 1'b1;
                    wdata.bytes = r_ok ? r_payload : 48'd0;
                end
                default: we = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.func == rlrt_pkg::FUNC_EVICT_ALL) begin
                        n_state = S_BUD;
                    end else if (i_req.func > rlrt_pkg::FUNC_EVICT_ALL ||
                                 i_req.asset_id == 32'd0 ||
                                 (i_req.func == rlrt_pkg::FUNC_ACQUIRE &&
                                  i_req.asset_kind == 4'd0)) begin
                        n_state = S_EREQ;
                    end else begin
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD:  n_state = S_FCHK;
            S_FCHK: begin
                if (r_idx != LAST_IDX) begin
                    n_state = S_FRD;
                end else if (r_found || r_func == rlrt_pkg::FUNC_ACQUIRE ||
                             (r_valid[r_idx] && r_rd.asset == r_id)) begin
                    n_state = S_UPD;
                end else begin
                    n_state = S_EREQ;
                end
            end
            S_UPD:  n_state = (r_func == rlrt_pkg::FUNC_COMPLETE) ? S_ADD : S_EREQ;
            S_ADD:  n_state = S_BUD;
            S_BUD: begin
                if (r_func == rlrt_pkg::FUNC_EVICT_ALL ||
                    (r_budget != 48'd0 && r_total > r_budget)) begin
                    n_state = S_ORD;
                end else begin
                    n_state = S_EREQ;
                end
            end
            S_ORD:  n_state = S_OCHK;
            S_OCHK: begin
                if (r_idx != LAST_IDX) begin
                    n_state = S_ORD;
                end else if (r_bok || (r_valid[r_idx] && r_rd.in_lru)) begin
                    n_state = S_EVICT;
                end else begin
                    n_state = S_EREQ;
                end
            end
            S_EVICT: n_state = S_BUD;
            S_EREQ: begin
                if (!r_req || ld_ok) begin
                    n_state = (r_evc != '0) ? S_EVRD : S_EST;
                end
            end
            S_EVRD: n_state = S_EVOUT;
            S_EVOUT: begin
                if (ld_ok) begin
                    n_state = (r_ei + CW'(1) == r_evc) ? S_EST : S_EVRD;
                end
            end
            S_EST: if (ld_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_live   <= '0;
            r_total  <= '0;
            r_clock  <= '0;
            r_budget <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_budget <= pwdata[47:0];
            end
            if (beat_ld) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_UPD: begin
                    if (r_func == rlrt_pkg::FUNC_ACQUIRE && !r_found && r_freeok) begin
                        r_valid[r_freeidx] <= 1'b1;
                        r_live             <= r_live + CW'(1);
                    end
                    if (r_func == rlrt_pkg::FUNC_RELEASE && r_rec.refs == 16'd1) begin
                        r_clock <= clk_inc;
                    end
                    if (r_func == rlrt_pkg::FUNC_COMPLETE) begin
                        r_total <= (r_rec.bytes > r_total) ? 48'd0 : r_total - r_rec.bytes;
                    end
                end
                S_ADD: r_total <= sum[48] ? rlrt_pkg::BYTES_MAX : sum[47:0];
                S_EVICT: begin
                    r_valid[r_bidx] <= 1'b0;
                    r_live          <= r_live - CW'(1);
                    r_total         <= evict_total;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_func    <= i_req.func;
                    r_id      <= i_req.asset_id;
                    r_kind    <= i_req.asset_kind;
                    r_lod     <= i_req.lod;
                    r_prio    <= i_req.priority_req;
                    r_payload <= i_req.payload_bytes;
                    r_ok      <= i_req.load_ok;
                    r_idx     <= '0;
                    r_found   <= 1'b0;
                    r_freeok  <= 1'b0;
                    r_bok     <= 1'b0;
                    r_req     <= 1'b0;
                    r_hit     <= 1'b0;
                    r_evc     <= '0;
                    r_ei      <= '0;
                    r_status  <= (i_req.func > rlrt_pkg::FUNC_EVICT_ALL ||
                                  (i_req.func != rlrt_pkg::FUNC_EVICT_ALL &&
                                   (i_req.asset_id == 32'd0 ||
                                    (i_req.func == rlrt_pkg::FUNC_ACQUIRE &&
                                     i_req.asset_kind == 4'd0)))) ?
                                 rlrt_pkg::ST_INVALID : rlrt_pkg::ST_OK;
                end
            end
            S_FCHK: begin
                if (!r_found && r_valid[r_idx] && r_rd.asset == r_id) begin
                    r_found <= 1'b1;
                    r_fidx  <= r_idx;
                    r_rec   <= r_rd;
                end
                if (!r_freeok && !r_valid[r_idx]) begin
                    r_freeok  <= 1'b1;
                    r_freeidx <= r_idx;
                end
                if (r_idx != LAST_IDX) begin
                    r_idx <= r_idx + IW'(1);
                end else if (!(r_found || (r_valid[r_idx] && r_rd.asset == r_id)) &&
                             r_func != rlrt_pkg::FUNC_ACQUIRE) begin
                    r_status <= rlrt_pkg::ST_STALE;
                end
            end
            S_UPD: begin
                unique case (r_func)
                    rlrt_pkg::FUNC_ACQUIRE: begin
                        if (r_found) begin
                            r_hit <= 1'b1;
                            if (r_rec.refs == rlrt_pkg::REF_MAX) begin
                                r_status <= rlrt_pkg::ST_SATURATED;
                            end
                        end else if (r_freeok) begin
                            r_req <= 1'b1;
                        end else begin
                            r_status <= rlrt_pkg::ST_FULL;
                        end
                    end
                    rlrt_pkg::FUNC_RETAIN: begin
                        if (r_rec.refs == rlrt_pkg::REF_MAX) begin
                            r_status <= rlrt_pkg::ST_SATURATED;
                        end
                    end
                    rlrt_pkg::FUNC_RELEASE: begin
                        if (r_rec.refs == 16'd0) begin
                            r_status <= rlrt_pkg::ST_UNDERFLOW;
                        end
                    end
                    default: r_b <= r_ok ? r_payload : 48'd0;
                endcase
            end
            S_BUD: begin
                r_idx <= '0;
                r_bok <= 1'b0;
            end
            S_OCHK: begin
                if (r_valid[r_idx] && r_rd.in_lru && (!r_bok || r_rd.stamp < r_bstamp)) begin
                    r_bok    <= 1'b1;
                    r_bidx   <= r_idx;
                    r_bstamp <= r_rd.stamp;
                    r_basset <= r_rd.asset;
                    r_bbytes <= r_rd.bytes;
                end
                if (r_idx != LAST_IDX) begin
                    r_idx <= r_idx + IW'(1);
                end
            end
            S_EVICT: r_evc <= r_evc + CW'(1);
            S_EREQ: begin
                if (r_req && ld_ok) begin
                    r_out <= '{result_kind: rlrt_pkg::RK_REQUEST, status: rlrt_pkg::ST_OK,
                               out_asset_id: r_id, out_kind: r_kind, out_lod: r_lod,
                               out_priority: r_prio, hit: 1'b0, freed_bytes: 48'd0,
                               last: 1'b0};
                end
            end
            S_EVOUT: begin
                if (ld_ok) begin
                    r_out <= '{result_kind: rlrt_pkg::RK_EVICT, status: rlrt_pkg::ST_OK,
                               out_asset_id: r_evrd.asset, out_kind: 4'd0, out_lod: 8'd0,
                               out_priority: 2'd0, hit: 1'b0, freed_bytes: r_evrd.bytes,
                               last: 1'b0};
                    r_ei <= r_ei + CW'(1);
                end
            end
            S_EST: begin
                if (ld_ok) begin
                    r_out <= '{result_kind: rlrt_pkg::RK_STATUS, status: r_status,
                               out_asset_id: r_id, out_kind: 4'd0, out_lod: 8'd0,
                               out_priority: 2'd0, hit: r_hit, freed_bytes: 48'd0,
                               last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.result_kind    = r_out.result_kind;
    assign o_rsp.status         = r_out.status;
    assign o_rsp.out_asset_id   = r_out.out_asset_id;
    assign o_rsp.out_kind       = r_out.out_kind;
    assign o_rsp.out_lod        = r_out.out_lod;
    assign o_rsp.out_priority   = r_out.out_priority;
    assign o_rsp.hit            = r_out.hit;
    assign o_rsp.freed_bytes    = r_out.freed_bytes;
    assign o_rsp.resident_total = r_total;
    assign o_rsp.live_entries   = 6'(r_live);
    assign o_rsp.evicted_count  = r_out.last ? 6'(r_evc) : 6'd0;
    assign o_rsp.last           = r_out.last;

    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_live))
        else $error("live count disagrees with valid bits");

    a_evict_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVICT) |-> (r_bok && r_valid[r_bidx]))
        else $error("eviction without a valid victim");

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVOUT) |-> (r_ei < r_evc))
        else $error("eviction beat index past recorded victims");

endmodule

@@ sim/rlrt_checker.sv @@
// Scoreboard for the refcounted LRU residency table: tracks byte_budget writes,
// predicts every result beat of each accepted request and compares the output.
// Depends on rlrt_pkg and the channel interfaces in rlrt_ifs.sv.
module rlrt_checker #(
    parameter int         ENTRIES     = 32,
    parameter logic [3:0] BUDGET_ADDR = 4'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlrt_req_if         req_mon,
    rlrt_rsp_if         rsp_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  rk;
        logic [2:0]  status;
        logic [31:0] id;
        logic [3:0]  kind;
        logic [7:0]  lod;
        logic [1:0]  prio;
        logic        hit;
        logic [47:0] freed;
        logic [47:0] total;
        logic [5:0]  live;
        logic [5:0]  evc;
        logic        last;
    } t_beat;

    bit          tab_valid [ENTRIES];
    logic [31:0] tab_asset [ENTRIES];
    logic [15:0] tab_refs  [ENTRIES];
    bit          tab_lru   [ENTRIES];
    logic [63:0] tab_stamp [ENTRIES];
    logic [47:0] tab_bytes [ENTRIES];
    logic [47:0] resident;
    logic [63:0] rel_clock;
    logic [47:0] budget;
    t_beat       expected_beats[$];
    t_beat       step_beats[$];
    int          err_count = 0;
    int          pending_count = 0;

    assign o_errors  = err_count;
    assign o_pending = pending_count;

    function automatic int lookup(logic [31:0] id);
        for (int i = 0; i < ENTRIES; i++)
            if (tab_valid[i] && tab_asset[i] == id) return i;
        return -1;
    endfunction

    function automatic int oldest_victim();
        int best;
        best = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (tab_valid[i] && tab_lru[i] && (best < 0 || tab_stamp[i] < tab_stamp[best]))
                best = i;
        return best;
    endfunction

    function automatic void add_beat(logic [1:0] rk, logic [2:0] st, logic [31:0] id,
                                     logic [3:0] kind, logic [7:0] lod, logic [1:0] prio,
                                     logic hit, logic [47:0] freed, logic [5:0] evc,
                                     logic last);
        t_beat b;
        b = '{rk, st, id, kind, lod, prio, hit, freed, 48'd0, 6'd0, evc, last};
        step_beats.push_back(b);
    endfunction

    function automatic void evict(int v);
        logic [47:0] freed;
        freed = tab_bytes[v];
        resident = (freed > resident) ? 48'd0 : resident - freed;
        tab_valid[v] = 0;
        tab_lru[v] = 0;
        add_beat(rlrt_pkg::RK_EVICT, rlrt_pkg::ST_OK, tab_asset[v], 4'd0, 8'd0, 2'd0,
                 1'b0, freed, 6'd0, 1'b0);
    endfunction

    function automatic void predict(logic [2:0] f, logic [31:0] id, logic [3:0] kind,
                                    logic [7:0] lod, logic [1:0] prio,
                                    logic [47:0] payload, logic ok);
        logic [2:0]  st;
        logic        hit;
        int          evc, s, v, live;
        logic [48:0] t;
        logic [47:0] b;
        t_beat       bt;
        st = rlrt_pkg::ST_OK; hit = 0; evc = 0;
        step_beats.delete();
        if (f == rlrt_pkg::FUNC_ACQUIRE) begin
            s = lookup(id);
            if (id == 0 || kind == 0) begin
                st = rlrt_pkg::ST_INVALID;
            end else if (s >= 0) begin
                hit = 1;
                tab_lru[s] = 0;
                if (tab_refs[s] == rlrt_pkg::REF_MAX) st = rlrt_pkg::ST_SATURATED;
                else tab_refs[s]++;
            end else begin
                s = 0;
                while (s < ENTRIES && tab_valid[s]) s++;
                if (s >= ENTRIES) begin
                    st = rlrt_pkg::ST_FULL;
                end else begin
                    tab_valid[s] = 1; tab_asset[s] = id; tab_refs[s] = 16'd1;
                    tab_lru[s] = 0; tab_stamp[s] = 64'd0; tab_bytes[s] = 48'd0;
                    add_beat(rlrt_pkg::RK_REQUEST, rlrt_pkg::ST_OK, id, kind, lod, prio,
                             1'b0, 48'd0, 6'd0, 1'b0);
                end
            end
        end else if (f == rlrt_pkg::FUNC_RETAIN || f == rlrt_pkg::FUNC_RELEASE ||
                     f == rlrt_pkg::FUNC_COMPLETE) begin
            s = lookup(id);
            if (id == 0) begin
                st = rlrt_pkg::ST_INVALID;
            end else if (s < 0) begin
                st = rlrt_pkg::ST_STALE;
            end else if (f == rlrt_pkg::FUNC_RETAIN) begin
                if (tab_refs[s] == 0) tab_lru[s] = 0;
                if (tab_refs[s] == rlrt_pkg::REF_MAX) st = rlrt_pkg::ST_SATURATED;
                else tab_refs[s]++;
            end else if (f == rlrt_pkg::FUNC_RELEASE) begin
                if (tab_refs[s] == 0) begin
                    st = rlrt_pkg::ST_UNDERFLOW;
                end else begin
                    tab_refs[s]--;
                    if (tab_refs[s] == 0) begin
                        if (rel_clock != rlrt_pkg::CLOCK_MAX) rel_clock++;
                        tab_stamp[s] = rel_clock;
                        tab_lru[s] = 1;
                    end
                end
            end else begin
                b = ok ? payload : 48'd0;
                t = (tab_bytes[s] > resident) ? 49'd0 : {1'b0, resident - tab_bytes[s]};
                t = t + {1'b0, b};
                resident = t[48] ? rlrt_pkg::BYTES_MAX : t[47:0];
                tab_bytes[s] = b;
                if (budget != 0) begin
                    while (resident > budget) begin
                        v = oldest_victim();
                        if (v < 0) break;
                        evict(v);
                        evc++;
                    end
                end
            end
        end else if (f == rlrt_pkg::FUNC_EVICT_ALL) begin
            v = oldest_victim();
            while (v >= 0) begin
                evict(v);
                evc++;
                v = oldest_victim();
            end
        end else begin
            st = rlrt_pkg::ST_INVALID;
        end
        add_beat(rlrt_pkg::RK_STATUS, st, id, 4'd0, 8'd0, 2'd0, hit, 48'd0, evc[5:0], 1'b1);
        live = 0;
        for (int k = 0; k < ENTRIES; k++) if (tab_valid[k]) live++;
        foreach (step_beats[k]) begin
            bt = step_beats[k];
            bt.total = resident;
            bt.live = live[5:0];
            expected_beats.push_back(bt);
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_beat e;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tab_valid[i] = 0;
                tab_lru[i] = 0;
            end
            resident = 0;
            rel_clock = 0;
            budget = 0;
            expected_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == BUDGET_ADDR)
                budget = pwdata[47:0];
            if (req_mon.valid && req_mon.ready)
                predict(req_mon.func, req_mon.asset_id, req_mon.asset_kind, req_mon.lod,
                        req_mon.priority_req, req_mon.payload_bytes, req_mon.load_ok);
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none, got id 0x%0h",
                             $time, rsp_mon.out_asset_id);
                    err_count++;
                end else begin
                    e = expected_beats[0];
                    expected_beats.delete(0);
                    check_field("result_kind", 64'(e.rk), 64'(rsp_mon.result_kind));
                    check_field("status", 64'(e.status), 64'(rsp_mon.status));
                    check_field("out_asset_id", 64'(e.id), 64'(rsp_mon.out_asset_id));
                    check_field("out_kind", 64'(e.kind), 64'(rsp_mon.out_kind));
                    check_field("out_lod", 64'(e.lod), 64'(rsp_mon.out_lod));
                    check_field("out_priority", 64'(e.prio), 64'(rsp_mon.out_priority));
                    check_field("hit", 64'(e.hit), 64'(rsp_mon.hit));
                    check_field("freed_bytes", 64'(e.freed), 64'(rsp_mon.freed_bytes));
                    check_field("resident_total", 64'(e.total),
                                64'(rsp_mon.resident_total));
                    check_field("live_entries", 64'(e.live), 64'(rsp_mon.live_entries));
                    check_field("evicted_count", 64'(e.evc), 64'(rsp_mon.evicted_count));
                    check_field("last", 64'(e.last), 64'(rsp_mon.last));
                end
            end
        end
        pending_count = expected_beats.size();
    end
endmodule

@@ sim/refcounted_lru_residency_table_core_tb.sv @@
// Testbench top for the refcounted LRU residency table: clock, reset, APB budget
// writes, request stimulus and result back-pressure; rlrt_checker does the checks.
// Depends on rlrt_pkg, rlrt_ifs.sv, rlrt_checker.sv and the core.
module refcounted_lru_residency_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ENTRIES         = 32;
    localparam logic [3:0] REG_BYTE_BUDGET = 4'd0;
    localparam int         DRAIN_CYCLES    = 4 * (2 * ENTRIES + 3);
    localparam int         CYCLE_LIMIT     = 2000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite, pready;
    logic [3:0]  paddr;
    logic [63:0] pwdata, prdata;
    int          errors, pending;
    int          cycles = 0;
    bit          sender_done;

    rlrt_req_if req_ch ();
    rlrt_rsp_if rsp_ch ();

    refcounted_lru_residency_table_core #(.ENTRIES(ENTRIES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    rlrt_checker #(.ENTRIES(ENTRIES), .BUDGET_ADDR(REG_BYTE_BUDGET)) scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .req_mon(req_ch), .rsp_mon(rsp_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("refcounted_lru_residency_table_core verification failed");
            $finish;
        end
    end

    // result back-pressure: random pattern, one long hold-off while requests keep coming
    initial begin
        int mode;
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (cycles > 3000 && cycles < 3700) begin
                rsp_ch.ready <= 1'b0;
                repeat (700) @(negedge i_clk);
            end
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60)) begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                endcase
                @(negedge i_clk);
            end
        end
    end

    int burst_left;

    task automatic send(logic [2:0] f, logic [31:0] id, logic [3:0] kind, logic [7:0] lod,
                        logic [1:0] prio, logic [47:0] bytes, logic ok);
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.asset_id <= id;
        req_ch.asset_kind <= kind;
        req_ch.lod <= lod;
        req_ch.priority_req <= prio;
        req_ch.payload_bytes <= bytes;
        req_ch.load_ok <= ok;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_budget(logic [47:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_BYTE_BUDGET; pwdata <= {16'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [47:0] rand_bytes();
        case ($urandom_range(0, 4))
            0: return 48'({$urandom, $urandom});
            1: return rlrt_pkg::BYTES_MAX - 48'($urandom_range(0, 3));
            default: return 48'($urandom_range(0, 5000));
        endcase
    endfunction

    function automatic logic [31:0] rand_id();
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return 32'd0;
            2: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic random_items(int count);
        int          r;
        logic [2:0]  f;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 35) f = rlrt_pkg::FUNC_ACQUIRE;
            else if (r < 45) f = rlrt_pkg::FUNC_RETAIN;
            else if (r < 70) f = rlrt_pkg::FUNC_RELEASE;
            else if (r < 92) f = rlrt_pkg::FUNC_COMPLETE;
            else if (r < 96) f = rlrt_pkg::FUNC_EVICT_ALL;
            else f = rlrt_pkg::FUNC_EVICT_ALL + 3'($urandom_range(1, 3));
            send(f, rand_id(), ($urandom_range(0, 15) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
                 8'($urandom), 2'($urandom), rand_bytes(), ($urandom_range(0, 4) != 0));
        end
    endtask

    initial begin
        logic [2:0] bad_func;
        burst_left = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_ch.valid = 1'b0; req_ch.func = rlrt_pkg::FUNC_ACQUIRE; req_ch.asset_id = '0;
        req_ch.asset_kind = '0; req_ch.lod = '0; req_ch.priority_req = '0;
        req_ch.payload_bytes = '0; req_ch.load_ok = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed cases, no budget
        send(rlrt_pkg::FUNC_ACQUIRE, 32'd0, 4'd3, 8'd1, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_ACQUIRE, 32'd5, 4'd0, 8'd1, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_ACQUIRE, 32'hFFFF_FFFF, 4'hF, 8'hFF, 2'd3,
             rlrt_pkg::BYTES_MAX, 1'b1);
        send(rlrt_pkg::FUNC_ACQUIRE, 32'hFFFF_FFFF, 4'h1, 8'h00, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_RETAIN, 32'hFFFF_FFFF, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_RETAIN, 32'hFFFF_FFFF, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_RELEASE, 32'hFFFF_FFFF, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_COMPLETE, 32'hFFFF_FFFF, 4'd0, 8'd0, 2'd0,
             rlrt_pkg::BYTES_MAX, 1'b1);
        send(rlrt_pkg::FUNC_ACQUIRE, 32'd7, 4'd2, 8'd9, 2'd1, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_COMPLETE, 32'd7, 4'd0, 8'd0, 2'd0, 48'd100, 1'b1);
        send(rlrt_pkg::FUNC_COMPLETE, 32'd7, 4'd0, 8'd0, 2'd0, 48'd40, 1'b1);
        send(rlrt_pkg::FUNC_COMPLETE, 32'd7, 4'd0, 8'd0, 2'd0, 48'd77, 1'b0);
        send(rlrt_pkg::FUNC_COMPLETE, 32'd0, 4'd0, 8'd0, 2'd0, 48'd1, 1'b1);
        send(rlrt_pkg::FUNC_RETAIN, 32'd1234, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_RELEASE, 32'd0, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        for (int k = 1; k <= 3; k++) begin
            bad_func = rlrt_pkg::FUNC_EVICT_ALL + 3'(k);
            send(bad_func, 32'd7, 4'd1, 8'd0, 2'd0, 48'd0, 1'b0);
        end
        send(rlrt_pkg::FUNC_RELEASE, 32'd7, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        send(rlrt_pkg::FUNC_EVICT_ALL, 32'd0, 4'd0, 8'd0, 2'd0, 48'd0, 1'b0);
        settle();

        // budget phases, extremes among them
        write_budget(48'd1);
        random_items(30);
        settle();
        write_budget(48'd4000);
        random_items(20);
        settle();
        write_budget(rlrt_pkg::BYTES_MAX);
        random_items(30);
        settle();
        write_budget(48'({$urandom, $urandom}));
        random_items(20);
        settle();
        write_budget(48'd0);
        random_items(30);
        settle();

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("refcounted_lru_residency_table_core verification clean");
        end else begin
            $display("refcounted_lru_residency_table_core verification failed");
        end
        $finish;
    end
endmodule
